@@ rtl/assert_macros.svh @@
// Assertion macros for the checker file of the deframer, stxef_checker.sv.
// Each macro expands to one labeled concurrent assertion on a rising clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STXEF_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("deframer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define STXEF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

@@ rtl/stxef_pkg.sv @@
// Shared constants for the STX/ETX deframer: field widths, register
// indexes and parameter defaults. No dependencies.
`default_nettype none

package stxef_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned LEN_W   = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam int unsigned MAX_PAYLOAD_DEF = 64;

  localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_MARKER   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_LIMIT = 2'd2;

  localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'h02;
  localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'h03;
  localparam logic [LEN_W-1:0]  LENGTH_LIMIT_RST = 7'd64;

endpackage

`default_nettype wire

@@ rtl/stxef_if.sv @@
// Valid/ready channel interfaces of the deframer: received bytes, released
// payload items and configuration writes. Uses stxef_pkg for widths.
`default_nettype none

interface stxef_in_if;
  logic                          valid;
  logic                          ready;
  logic [stxef_pkg::BYTE_W-1:0]  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface stxef_out_if;
  logic                          valid;
  logic                          ready;
  logic [stxef_pkg::BYTE_W-1:0]  payload_byte;
  logic [stxef_pkg::POS_W-1:0]   byte_position;
  logic [stxef_pkg::LEN_W-1:0]   frame_length;
  logic                          last_of_frame;
  logic                          empty_frame;

  modport source (output valid, output payload_byte, output byte_position,
                  output frame_length, output last_of_frame, output empty_frame,
                  input ready);
  modport sink   (input valid, input payload_byte, input byte_position,
                  input frame_length, input last_of_frame, input empty_frame,
                  output ready);
endinterface

interface stxef_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [stxef_pkg::CFG_IDX_W-1:0]   reg_index;
  logic [stxef_pkg::CFG_DATA_W-1:0]  wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

@@ rtl/stx_etx_frame_extractor_core.sv @@
// STX/ETX byte deframer, top level. Depends on stxef_pkg and the channel
// interfaces in stxef_if.sv.
//
// One received byte enters per item on rx_i. Outside a frame every byte but
// the start marker is dropped; inside a frame data bytes go into a payload
// memory of MAX_PAYLOAD bytes, a start marker restarts the frame, and a byte
// past the length limit (saturated at MAX_PAYLOAD) discards the frame. The
// end marker releases the stored payload on res_o, one item per byte in
// order, or a single item flagged empty_frame when nothing was stored.
// While collecting, the block takes one byte every cycle. On the end marker
// it stops taking bytes until the last item of the run is loaded into the
// output register: each byte is read in order through the single registered
// read port of the payload memory, one read in flight, and a stall on res_o
// holds the run; an empty frame loads only its flagged item. The output
// register lets the next frame start while the final item still waits to be
// taken. The payload memory has no reset and needs no clearing pass: only
// entries written in the current frame are read.
// Configuration writes on cfg_i are always taken; write them while idle.
`default_nettype none

module stx_etx_frame_extractor_core #(
  parameter int unsigned MAX_PAYLOAD = stxef_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  stxef_cfg_if.sink     cfg_i,
  stxef_in_if.sink      rx_i,
  stxef_out_if.source   res_o
);

  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);
  localparam logic [stxef_pkg::LEN_W-1:0] MaxLen = stxef_pkg::LEN_W'(MAX_PAYLOAD);

  localparam logic ST_IDLE    = 1'b0;
  localparam logic ST_RELEASE = 1'b1;

  // Configuration registers
  logic [stxef_pkg::BYTE_W-1:0] start_q;
  logic [stxef_pkg::BYTE_W-1:0] end_q;
  logic [stxef_pkg::LEN_W-1:0]  limit_q;

  // Framing and release control
  logic          state_q;
  logic          inside_q;
  logic [CW-1:0] fill_q;
  logic [CW-1:0] len_q;
  logic [CW-1:0] rd_cnt_q;
  logic [CW-1:0] ld_cnt_q;
  logic          rd_pend_q;
  logic          rd_pend_d;

  // Payload memory and its registered read data
  logic [stxef_pkg::BYTE_W-1:0] payload_mem [MAX_PAYLOAD];
  logic [stxef_pkg::BYTE_W-1:0] rdata_q;

  // Output register
  logic                         res_valid_q;
  logic [stxef_pkg::BYTE_W-1:0] res_byte_q;
  logic [stxef_pkg::POS_W-1:0]  res_pos_q;
  logic [stxef_pkg::LEN_W-1:0]  res_len_q;
  logic                         res_last_q;
  logic                         res_empty_q;

  logic                         cfg_fire;
  logic                         rx_fire;
  logic                         is_start;
  logic                         is_end;
  logic [stxef_pkg::LEN_W-1:0]  eff_limit;
  logic                         room;
  logic                         wr_en;
  logic                         out_free;
  logic                         load_byte;
  logic                         load_empty;
  logic                         rd_issue;
  logic                         last_byte;

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid & cfg_i.ready;

  // Bytes are taken only while collecting; the release run owns the memory port.
  assign rx_i.ready = (state_q == ST_IDLE);
  assign rx_fire    = rx_i.valid & rx_i.ready;

  assign is_start  = (rx_i.rx_byte == start_q);
  assign is_end    = (rx_i.rx_byte == end_q);
  assign eff_limit = (limit_q > MaxLen) ? MaxLen : limit_q;
  assign room      = (stxef_pkg::LEN_W'(fill_q) < eff_limit);

  // The end-marker test wins over the start-marker test inside a frame.
  assign wr_en = rx_fire & inside_q & ~is_end & ~is_start & room;

  assign out_free   = ~res_valid_q | res_o.ready;
  assign load_byte  = (state_q == ST_RELEASE) & rd_pend_q & out_free;
  assign load_empty = (state_q == ST_RELEASE) & (len_q == '0) & out_free;
  // Keep at most one read in flight: issue the next one as the pending one drains.
  assign rd_issue   = (state_q == ST_RELEASE) & (rd_cnt_q < len_q)
                    & (~rd_pend_q | load_byte);
  assign rd_pend_d  = rd_issue | (rd_pend_q & ~load_byte);
  assign last_byte  = ((ld_cnt_q + CW'(1)) == len_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= stxef_pkg::START_MARKER_RST;
      end_q   <= stxef_pkg::END_MARKER_RST;
      limit_q <= stxef_pkg::LENGTH_LIMIT_RST;
    end else if (cfg_fire) begin
      case (cfg_i.reg_index)
        stxef_pkg::REG_START_MARKER: start_q <= cfg_i.wdata;
        stxef_pkg::REG_END_MARKER:   end_q   <= cfg_i.wdata;
        stxef_pkg::REG_LENGTH_LIMIT: limit_q <= cfg_i.wdata[stxef_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      inside_q  <= 1'b0;
      fill_q    <= '0;
      len_q     <= '0;
      rd_cnt_q  <= '0;
      ld_cnt_q  <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= rd_pend_d;
      case (state_q)
        ST_IDLE: begin
          if (rx_fire) begin
            if (!inside_q) begin
              if (is_start) begin
                inside_q <= 1'b1;
                fill_q   <= '0;
              end
            end else if (is_end) begin
              // Close the frame and hand the count to the release run.
              inside_q <= 1'b0;
              len_q    <= fill_q;
              fill_q   <= '0;
              rd_cnt_q <= '0;
              ld_cnt_q <= '0;
              state_q  <= ST_RELEASE;
            end else if (is_start) begin
              fill_q <= '0;
            end else if (room) begin
              fill_q <= fill_q + CW'(1);
            end else begin
              // Overflow: drop the frame without any item.
              inside_q <= 1'b0;
              fill_q   <= '0;
            end
          end
        end
        ST_RELEASE: begin
          if (rd_issue) begin
            rd_cnt_q <= rd_cnt_q + CW'(1);
          end
          if (load_byte) begin
            ld_cnt_q <= ld_cnt_q + CW'(1);
          end
          if (load_empty || (load_byte && last_byte)) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Single write port while collecting, single registered read port on release.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      payload_mem[fill_q[AW-1:0]] <= rx_i.rx_byte;
    end
    if (rd_issue) begin
      rdata_q <= payload_mem[rd_cnt_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (load_byte || load_empty) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_empty) begin
      res_byte_q  <= '0;
      res_pos_q   <= '0;
      res_len_q   <= '0;
      res_last_q  <= 1'b1;
      res_empty_q <= 1'b1;
    end else if (load_byte) begin
      res_byte_q  <= rdata_q;
      res_pos_q   <= stxef_pkg::POS_W'(ld_cnt_q);
      res_len_q   <= stxef_pkg::LEN_W'(len_q);
      res_last_q  <= last_byte;
      res_empty_q <= 1'b0;
    end
  end

  assign res_o.valid         = res_valid_q;
  assign res_o.payload_byte  = res_byte_q;
  assign res_o.byte_position = res_pos_q;
  assign res_o.frame_length  = res_len_q;
  assign res_o.last_of_frame = res_last_q;
  assign res_o.empty_frame   = res_empty_q;

endmodule

`default_nettype wire

@@ rtl/stxef_checker.sv @@
// Port-level checks for the deframer top level, attached by bind.
// Depends on stxef_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module stxef_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          res_valid_i,
  input wire logic                          res_ready_i,
  input wire logic [stxef_pkg::BYTE_W-1:0]  res_byte_i,
  input wire logic [stxef_pkg::POS_W-1:0]   res_pos_i,
  input wire logic [stxef_pkg::LEN_W-1:0]   res_len_i,
  input wire logic                          res_last_i,
  input wire logic                          res_empty_i
);

  // Hold a stalled item.
  `STXEF_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, res_valid_i && !res_ready_i, res_valid_i && $stable(res_byte_i) && $stable(res_pos_i) && $stable(res_len_i) && $stable(res_last_i))

  // An empty frame is a single closing item with zeroed fields.
  `STXEF_ASSERT_IMPL(a_empty_shape, clk_i, rst_ni, res_valid_i && res_empty_i, res_last_i && (res_byte_i == '0) && (res_pos_i == '0) && (res_len_i == '0))

  // A payload item lies inside its frame.
  `STXEF_ASSERT_IMPL(a_pos_in_frame, clk_i, rst_ni, res_valid_i && !res_empty_i, stxef_pkg::LEN_W'(res_pos_i) < res_len_i)

  // The last payload item sits at the final position.
  `STXEF_ASSERT_IMPL(a_last_pos, clk_i, rst_ni, res_valid_i && !res_empty_i && res_last_i, (stxef_pkg::LEN_W'(res_pos_i) + stxef_pkg::LEN_W'(1)) == res_len_i)

endmodule

bind stx_etx_frame_extractor_core stxef_checker u_stxef_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_byte_i  (res_o.payload_byte),
  .res_pos_i   (res_o.byte_position),
  .res_len_i   (res_o.frame_length),
  .res_last_i  (res_o.last_of_frame),
  .res_empty_i (res_o.empty_frame)
);

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for stx_etx_frame_extractor_core: drives bytes, register
// writes and output stalls, predicts every released payload item in SV.
// Depends on stxef_pkg, the channel interfaces in stxef_if.sv and the core.

module tb;

  localparam int unsigned MAX_PL      = stxef_pkg::MAX_PAYLOAD_DEF;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned PHASE_ITEMS = 8;

  // One released payload item as the block should present it.
  typedef struct packed {
    logic [stxef_pkg::BYTE_W-1:0] payload;
    logic [stxef_pkg::POS_W-1:0]  pos;
    logic [stxef_pkg::LEN_W-1:0]  len;
    logic                         is_last;
    logic                         is_empty;
  } release_t;

  logic clk;
  logic rst_n;

  stxef_cfg_if cfg_if ();
  stxef_in_if  rx_if ();
  stxef_out_if res_if ();

  stx_etx_frame_extractor_core #(
    .MAX_PAYLOAD(MAX_PL)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_if),
    .rx_i  (rx_if),
    .res_o (res_if)
  );

  // Deframer shadow: registers and frame state as the block should hold them.
  logic [stxef_pkg::BYTE_W-1:0] cfg_start;
  logic [stxef_pkg::BYTE_W-1:0] cfg_end;
  logic [stxef_pkg::LEN_W-1:0]  cfg_limit;
  logic                         in_frame_m;
  int                           fill_m;
  logic [stxef_pkg::BYTE_W-1:0] store_m [MAX_PL];

  release_t release_q[$];   // payload items still owed by the block
  int       used_items;     // bytes the deframer acted on (not ignored)
  int       errors;
  int       cycles;

  // Idle control; written with nonblocking assignments so that readers at the
  // same edge always see the previous value.
  logic in_gaps_on;
  logic out_stalls_on;
  logic hold_out;
  int   stall_left;

  always #1 clk = ~clk;

  // Hard stop: a hung handshake ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items pending", cycles, release_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Mostly no gap, some short ones, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int eff_limit();
    return (cfg_limit > MAX_PL) ? MAX_PL : int'(cfg_limit);
  endfunction

  // Advance the shadow deframer by one accepted byte and queue the items
  // that an end marker releases.
  function automatic void deframe_byte(input logic [stxef_pkg::BYTE_W-1:0] b);
    release_t r;
    int       n;
    if (!in_frame_m) begin
      // outside a frame only the start marker matters
      if (b == cfg_start) begin
        in_frame_m = 1'b1;
        fill_m     = 0;
        used_items++;
      end
      return;
    end
    used_items++;
    // end marker wins over start marker when both match
    if (b == cfg_end) begin
      n          = fill_m;
      in_frame_m = 1'b0;
      fill_m     = 0;
      if (n == 0) begin
        r = '{payload: '0, pos: '0, len: '0, is_last: 1'b1, is_empty: 1'b1};
        release_q.push_back(r);
      end else begin
        for (int k = 0; k < n; k++) begin
          r.payload  = store_m[k];
          r.pos      = stxef_pkg::POS_W'(k);
          r.len      = stxef_pkg::LEN_W'(n);
          r.is_last  = (k == n - 1);
          r.is_empty = 1'b0;
          release_q.push_back(r);
        end
      end
    end else if (b == cfg_start) begin
      fill_m = 0;                       // resync: drop what was collected
    end else if (fill_m < eff_limit()) begin
      store_m[fill_m] = b;
      fill_m++;
    end else begin
      in_frame_m = 1'b0;                // overflow: discard, no result
      fill_m     = 0;
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= 40)
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
  endtask

  // Hold one byte on the input until it is taken. Valid stays high across
  // back-to-back bytes; it is only lowered ahead of a gap or by drain_results.
  task automatic send_byte(input logic [stxef_pkg::BYTE_W-1:0] b);
    int gap;
    gap = in_gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (!rx_if.ready);
    deframe_byte(b);
  endtask

  task automatic write_reg(input logic [stxef_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [stxef_pkg::CFG_DATA_W-1:0] data);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wdata     <= data;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      stxef_pkg::REG_START_MARKER: cfg_start = data;
      stxef_pkg::REG_END_MARKER:   cfg_end   = data;
      stxef_pkg::REG_LENGTH_LIMIT: cfg_limit = data[stxef_pkg::LEN_W-1:0];
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_config(input logic [7:0] s, input logic [7:0] e, input logic [7:0] l);
    write_reg(stxef_pkg::REG_START_MARKER, s);
    write_reg(stxef_pkg::REG_END_MARKER, e);
    write_reg(stxef_pkg::REG_LENGTH_LIMIT, l);
  endtask

  // Stop offering bytes, wait out every owed item, then let the block settle
  // so that a register write can follow safely.
  task automatic drain_results();
    rx_if.valid <= 1'b0;
    while (release_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // One frame with random content; a minority are loose bytes or frames that
  // never see their end marker.
  task automatic run_frame();
    int                           lim;
    int                           n;
    int                           r;
    logic [stxef_pkg::BYTE_W-1:0] d;
    lim = eff_limit();
    r   = $urandom_range(0, 99);
    if (r < 10) begin
      repeat ($urandom_range(1, 3))
        send_byte(stxef_pkg::BYTE_W'($urandom_range(0, 255)));
      return;
    end
    n = $urandom_range(0, 99);
    if (n < 70)      n = $urandom_range(0, (lim < 6) ? lim + 1 : 6);
    else if (n < 90) n = $urandom_range(0, lim);
    else             n = lim + $urandom_range(0, 1);   // exactly full or one over
    send_byte(cfg_start);
    repeat (n) begin
      do d = stxef_pkg::BYTE_W'($urandom_range(0, 255));
      while (d == cfg_start || d == cfg_end);
      send_byte(d);
    end
    if (r >= 18) send_byte(cfg_end);   // otherwise leave it open
  endtask

  // Reset marker values: ignored bytes, empty frame, byte extremes, resync.
  task automatic test_directed();
    send_byte(8'h41);
    send_byte(stxef_pkg::END_MARKER_RST);
    send_byte(stxef_pkg::START_MARKER_RST);
    send_byte(stxef_pkg::END_MARKER_RST);
    send_byte(stxef_pkg::START_MARKER_RST);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(stxef_pkg::END_MARKER_RST);
    send_byte(stxef_pkg::START_MARKER_RST);
    send_byte(8'hAA);
    send_byte(stxef_pkg::START_MARKER_RST);
    send_byte(8'hBB);
    send_byte(stxef_pkg::END_MARKER_RST);
    drain_results();
  endtask

  // Equal markers, a limit of one with overflow, then a limit of zero.
  task automatic test_marker_cases();
    apply_config(8'h55, 8'h55, 8'd1);
    send_byte(8'h55);
    send_byte(8'h55);
    send_byte(8'h55);
    send_byte(8'h10);
    send_byte(8'h55);
    send_byte(8'h55);
    send_byte(8'h10);
    send_byte(8'h11);
    drain_results();
    write_reg(stxef_pkg::REG_LENGTH_LIMIT, 8'd0);
    send_byte(8'h55);
    send_byte(8'h55);
    send_byte(8'h55);
    send_byte(8'h20);
    drain_results();
  endtask

  // Hold the output off for a long stretch while bytes keep coming, so the
  // block fills its output register and stalls its input.
  task automatic test_backpressure();
    apply_config(stxef_pkg::START_MARKER_RST, stxef_pkg::END_MARKER_RST,
                 8'(stxef_pkg::LENGTH_LIMIT_RST));
    in_gaps_on    <= 1'b0;
    out_stalls_on <= 1'b0;
    fork
      begin
        hold_out <= 1'b1;
        repeat (300) @(posedge clk);
        hold_out <= 1'b0;
      end
      begin
        repeat (2) begin
          send_byte(stxef_pkg::START_MARKER_RST);
          repeat (8) send_byte(stxef_pkg::BYTE_W'($urandom_range(0, 255) | 8'h80));
          send_byte(stxef_pkg::END_MARKER_RST);
        end
      end
    join
    drain_results();
  endtask

  // Several register settings, extremes among them, each with random frames.
  task automatic test_random();
    int start_items;
    for (int p = 0; p < 6; p++) begin
      in_gaps_on    <= (p == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
      out_stalls_on <= (p == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
      case (p)
        0: apply_config(8'h02, 8'h03, 8'd64);
        1: apply_config(8'h00, 8'hFF, 8'd1);
        2: apply_config(8'hFF, 8'h00, 8'd127);   // saturates at the store size
        3: apply_config(8'hA5, 8'hA5, 8'd0);
        4: apply_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)));
        default: apply_config(8'h7E, 8'h7D, 8'hC8);  // top bit dropped, 72
      endcase
      start_items = used_items;
      while (used_items - start_items < PHASE_ITEMS) run_frame();
      drain_results();
    end
  endtask

  // Output side: random stalls unless the long hold-off is active.
  always @(posedge clk) begin
    if (hold_out) begin
      res_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      res_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (out_stalls_on && $urandom_range(0, 3) == 0) begin
      res_if.ready <= 1'b0;
      stall_left   <= pick_gap();
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // Compare every taken item with the oldest owed one.
  always @(posedge clk) begin
    release_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (release_q.size() == 0) begin
        report_mismatch("item with nothing owed, payload_byte", res_if.payload_byte, -1);
      end else begin
        want = release_q.pop_front();
        if (res_if.payload_byte !== want.payload)
          report_mismatch("payload_byte", res_if.payload_byte, want.payload);
        if (res_if.byte_position !== want.pos)
          report_mismatch("byte_position", res_if.byte_position, want.pos);
        if (res_if.frame_length !== want.len)
          report_mismatch("frame_length", res_if.frame_length, want.len);
        if (res_if.last_of_frame !== want.is_last)
          report_mismatch("last_of_frame", res_if.last_of_frame, want.is_last);
        if (res_if.empty_frame !== want.is_empty)
          report_mismatch("empty_frame", res_if.empty_frame, want.is_empty);
      end
    end
  end

  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    cycles           = 0;
    errors           = 0;
    used_items       = 0;
    stall_left       = 0;
    hold_out         = 1'b0;
    in_gaps_on       = 1'b1;
    out_stalls_on    = 1'b1;
    rx_if.valid      = 1'b0;
    rx_if.rx_byte    = '0;
    res_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.reg_index = stxef_pkg::REG_START_MARKER;
    cfg_if.wdata     = '0;
    cfg_start        = stxef_pkg::START_MARKER_RST;
    cfg_end          = stxef_pkg::END_MARKER_RST;
    cfg_limit        = stxef_pkg::LENGTH_LIMIT_RST;
    in_frame_m       = 1'b0;
    fill_m           = 0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_marker_cases();
    test_backpressure();
    test_random();

    // nothing owed any more; watch for stray items before the verdict
    repeat (MAX_PL + 10) @(posedge clk);
    if (errors == 0 && release_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
